// ----- rtl/eau_pkg.sv -----
// Shared types and constants for the effective address unit.
// Used by eau_regfile, eau_agen and effective_address_unit; depends on nothing.

package eau_pkg;

   localparam int unsigned REG_COUNT = 16;
   localparam int unsigned REG_AW    = $clog2(REG_COUNT);

   // stack pointer register number within the address bank
   localparam logic [2:0] SP_REG = 3'd7;

   // commands
   localparam logic CMD_WRITE   = 1'b0;
   localparam logic CMD_RESOLVE = 1'b1;

   // addressing modes
   localparam logic [2:0] MODE_DN_DIRECT   = 3'd0;
   localparam logic [2:0] MODE_AN_DIRECT   = 3'd1;
   localparam logic [2:0] MODE_AN_INDIRECT = 3'd2;
   localparam logic [2:0] MODE_POSTINC     = 3'd3;
   localparam logic [2:0] MODE_PREDEC      = 3'd4;
   localparam logic [2:0] MODE_DISP        = 3'd5;
   localparam logic [2:0] MODE_INDEX       = 3'd6;
   localparam logic [2:0] MODE_SPECIAL     = 3'd7;

   // submodes of MODE_SPECIAL
   localparam logic [2:0] SUB_ABS_W  = 3'd0;
   localparam logic [2:0] SUB_ABS_L  = 3'd1;
   localparam logic [2:0] SUB_PCDISP = 3'd2;
   localparam logic [2:0] SUB_PCIDX  = 3'd3;
   localparam logic [2:0] SUB_IMM    = 3'd4;

   // operand sizes
   localparam logic [1:0] SZ_BYTE = 2'd0;
   localparam logic [1:0] SZ_WORD = 2'd1;

   // operand kinds
   localparam logic [1:0] KIND_DREG = 2'd0;
   localparam logic [1:0] KIND_AREG = 2'd1;
   localparam logic [1:0] KIND_MEM  = 2'd2;
   localparam logic [1:0] KIND_IMM  = 2'd3;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_RANGE     = 3'd1;
   localparam logic [2:0] ERR_ODD       = 3'd2;
   localparam logic [2:0] ERR_BYTE_AREG = 3'd3;
   localparam logic [2:0] ERR_ILLEGAL   = 3'd4;

   // index extension word layout
   localparam int unsigned IDX_LONG_BIT = 11;
   localparam int unsigned IDX_REG_LSB  = 12;

   typedef struct packed {
      logic        command;
      logic [2:0]  mode;
      logic [2:0]  reg_req;
      logic [1:0]  size;
      logic [15:0] ext_word;
      logic [31:0] ext_long;
      logic [31:0] pc;
      logic [3:0]  write_index;
      logic [31:0] write_value;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  reg_number;
      logic [31:0] address;
      logic [1:0]  words_used;
      logic [2:0]  error_code;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] idx;
      logic [31:0]       data;
   } wr_type;

endpackage

// ----- rtl/eau_if.sv -----
// Request and response channel interfaces (valid/ready handshake).
// Field widths follow the effective address unit's request and response.

interface eau_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [2:0]  mode;
   logic [2:0]  reg_req;
   logic [1:0]  size;
   logic [15:0] ext_word;
   logic [31:0] ext_long;
   logic [31:0] pc;
   logic [3:0]  write_index;
   logic [31:0] write_value;

   modport source (
      output valid, command, mode, reg_req, size, ext_word, ext_long, pc,
             write_index, write_value,
      input  ready
   );
   modport sink (
      input  valid, command, mode, reg_req, size, ext_word, ext_long, pc,
             write_index, write_value,
      output ready
   );
endinterface

interface eau_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [2:0]  reg_number;
   logic [31:0] address;
   logic [1:0]  words_used;
   logic [2:0]  error_code;

   modport source (
      output valid, kind, reg_number, address, words_used, error_code,
      input  ready
   );
   modport sink (
      input  valid, kind, reg_number, address, words_used, error_code,
      output ready
   );
endinterface

// ----- rtl/eau_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// Read during write to the same entry returns the old contents.

module eau_ram #(
   parameter int unsigned DATA_WIDTH = 32,
   parameter int unsigned DEPTH      = 16
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [DATA_WIDTH-1:0]        wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [DATA_WIDTH-1:0]        rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/eau_regfile.sv -----
// Register file: two RAM copies give two read ports, valid bits stand in
// for the all-zero reset, and a same-edge write is forwarded to the reads.
// Depends on eau_pkg and eau_ram.

module eau_regfile (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [eau_pkg::REG_AW-1:0]   rd_a_addr,
   input  logic [eau_pkg::REG_AW-1:0]   rd_b_addr,
   input  eau_pkg::wr_type              wr,
   output logic [31:0]                  rd_a_data,
   output logic [31:0]                  rd_b_data
);

   logic [eau_pkg::REG_COUNT-1:0] valid_ff;
   logic [eau_pkg::REG_COUNT-1:0] valid_in;
   logic        a_vld_ff, b_vld_ff;
   logic        a_hit_ff, b_hit_ff;
   logic [31:0] fwd_data_ff;
   logic [31:0] ram_a_q, ram_b_q;

   eau_ram #(.DATA_WIDTH(32), .DEPTH(eau_pkg::REG_COUNT)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.idx),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_a_addr),
      .rd_data (ram_a_q)
   );

   eau_ram #(.DATA_WIDTH(32), .DEPTH(eau_pkg::REG_COUNT)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.idx),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (rd_b_addr),
      .rd_data (ram_b_q)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wr.en) begin
         valid_in[wr.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // read side status is captured with the read and held while the reader stalls
   always_ff @(posedge clock) begin
      if (rd_en) begin
         a_vld_ff    <= valid_ff[rd_a_addr];
         b_vld_ff    <= valid_ff[rd_b_addr];
         a_hit_ff    <= wr.en && (wr.idx == rd_a_addr);
         b_hit_ff    <= wr.en && (wr.idx == rd_b_addr);
         fwd_data_ff <= wr.data;
      end
   end

   assign rd_a_data = a_hit_ff ? fwd_data_ff : (a_vld_ff ? ram_a_q : 32'd0);
   assign rd_b_data = b_hit_ff ? fwd_data_ff : (b_vld_ff ? ram_b_q : 32'd0);

endmodule

// ----- rtl/eau_agen.sv -----
// Address generation: decodes mode/submode, forms the operand address,
// checks range and alignment, and builds the register write-back.
// Depends on eau_pkg.

module eau_agen (
   input  eau_pkg::req_type  req,
   input  logic [31:0]       an_val,
   input  logic [31:0]       idx_val,
   input  logic [31:0]       last_addr,
   output eau_pkg::rsp_type  rsp,
   output eau_pkg::wr_type   wb
);

   function automatic logic [2:0] mem_check(input logic [31:0] ad, input logic byte_op,
                                            input logic [31:0] last);
      logic [2:0] e;
      e = eau_pkg::ERR_NONE;
      if (ad > last) begin
         e = eau_pkg::ERR_RANGE;
      end else if (!byte_op && ad[0]) begin
         e = eau_pkg::ERR_ODD;
      end
      return e;
   endfunction

   logic        byte_op;
   logic [2:0]  step;
   logic [31:0] disp16;
   logic [31:0] xval;
   logic [31:0] idx_term;
   logic [31:0] base;
   logic [31:0] offset;
   logic [31:0] ea;
   logic [31:0] an_inc;
   logic [31:0] an_dec;
   logic        special;

   always_comb begin
      byte_op = (req.size == eau_pkg::SZ_BYTE);
      // size 3 acts as long; byte steps on A7 keep the stack even
      if (req.size[1]) begin
         step = 3'd4;
      end else if (req.size == eau_pkg::SZ_WORD || req.reg_req == eau_pkg::SP_REG) begin
         step = 3'd2;
      end else begin
         step = 3'd1;
      end
      an_inc = an_val + {29'd0, step};
      an_dec = an_val - {29'd0, step};

      disp16 = {{16{req.ext_word[15]}}, req.ext_word};
      xval   = req.ext_word[eau_pkg::IDX_LONG_BIT] ? idx_val
                                                   : {{16{idx_val[15]}}, idx_val[15:0]};
      idx_term = xval + {{24{req.ext_word[7]}}, req.ext_word[7:0]};

      special = (req.mode == eau_pkg::MODE_SPECIAL);
      if (!special) begin
         base = an_val;
      end else if (req.reg_req == eau_pkg::SUB_PCDISP || req.reg_req == eau_pkg::SUB_PCIDX) begin
         base = req.pc;
      end else begin
         base = 32'd0;
      end
      if (req.mode == eau_pkg::MODE_INDEX || (special && req.reg_req == eau_pkg::SUB_PCIDX)) begin
         offset = idx_term;
      end else begin
         offset = disp16;
      end
      ea = base + offset;
   end

   always_comb begin
      rsp            = '0;
      rsp.kind       = eau_pkg::KIND_MEM;
      wb             = '0;
      wb.idx         = {1'b1, req.reg_req};
      case (req.mode)
         eau_pkg::MODE_DN_DIRECT: begin
            rsp.kind       = eau_pkg::KIND_DREG;
            rsp.reg_number = req.reg_req;
         end
         eau_pkg::MODE_AN_DIRECT: begin
            rsp.kind       = eau_pkg::KIND_AREG;
            rsp.reg_number = req.reg_req;
            if (byte_op) begin
               rsp.error_code = eau_pkg::ERR_BYTE_AREG;
            end
         end
         eau_pkg::MODE_AN_INDIRECT: begin
            rsp.address    = an_val;
            rsp.error_code = mem_check(an_val, byte_op, last_addr);
         end
         eau_pkg::MODE_POSTINC: begin
            rsp.address    = an_val;
            rsp.error_code = mem_check(an_val, byte_op, last_addr);
            wb.en          = (rsp.error_code == eau_pkg::ERR_NONE);
            wb.data        = an_inc;
         end
         eau_pkg::MODE_PREDEC: begin
            rsp.address    = an_dec;
            rsp.error_code = mem_check(an_dec, byte_op, last_addr);
            wb.en          = (rsp.error_code == eau_pkg::ERR_NONE);
            wb.data        = an_dec;
         end
         eau_pkg::MODE_DISP, eau_pkg::MODE_INDEX: begin
            rsp.address    = ea;
            rsp.words_used = 2'd1;
            rsp.error_code = mem_check(ea, byte_op, last_addr);
         end
         default: begin
            case (req.reg_req)
               eau_pkg::SUB_ABS_W, eau_pkg::SUB_PCDISP, eau_pkg::SUB_PCIDX: begin
                  rsp.address    = ea;
                  rsp.words_used = 2'd1;
                  rsp.error_code = mem_check(ea, byte_op, last_addr);
               end
               eau_pkg::SUB_ABS_L: begin
                  rsp.address    = req.ext_long;
                  rsp.words_used = 2'd2;
                  rsp.error_code = mem_check(req.ext_long, byte_op, last_addr);
               end
               eau_pkg::SUB_IMM: begin
                  rsp.kind = eau_pkg::KIND_IMM;
                  // a byte immediate sits in the low byte of its word
                  rsp.address    = req.pc + {31'd0, byte_op};
                  rsp.words_used = req.size[1] ? 2'd2 : 2'd1;
               end
               default: begin
                  rsp.kind       = eau_pkg::KIND_DREG;
                  rsp.error_code = eau_pkg::ERR_ILLEGAL;
               end
            endcase
         end
      endcase

      if (req.command == eau_pkg::CMD_WRITE) begin
         wb.en   = 1'b1;
         wb.idx  = req.write_index;
         wb.data = req.write_value;
      end
   end

endmodule

// ----- rtl/effective_address_unit.sv -----
// Effective address unit: register file in RAM, address generation, output register.
// An accepted request is registered in s1_req_ff; its response is registered in rsp_data_ff.
// Throughput: one request per cycle unless responses stall; forwarding of write-back
// lets requests run back to back. Reset clears the register valid bits (all registers
// read as zero) and sets the memory limit to all ones; there is no clearing pass.
// Write requests give no response. Depends on eau_pkg, eau_if, eau_regfile, eau_agen.

module effective_address_unit (
   input  logic          clock,
   input  logic          reset,
   eau_req_if.sink       req_chan,
   eau_rsp_if.source     rsp_chan,
   input  logic          csr_write_en,
   input  logic [31:0]   csr_write_data
);

   logic              req_accept;
   eau_pkg::req_type  req_in;
   eau_pkg::req_type  s1_req_ff;
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_advance;
   logic              out_free;
   logic              rsp_valid_ff, rsp_valid_in;
   eau_pkg::rsp_type  rsp_data_ff;
   eau_pkg::rsp_type  agen_rsp;
   eau_pkg::wr_type   agen_wb;
   eau_pkg::wr_type   rf_wr;
   logic [31:0]       an_val, idx_val;
   logic [31:0]       mem_last_ff;

   assign req_in.command     = req_chan.command;
   assign req_in.mode        = req_chan.mode;
   assign req_in.reg_req     = req_chan.reg_req;
   assign req_in.size        = req_chan.size;
   assign req_in.ext_word    = req_chan.ext_word;
   assign req_in.ext_long    = req_chan.ext_long;
   assign req_in.pc          = req_chan.pc;
   assign req_in.write_index = req_chan.write_index;
   assign req_in.write_value = req_chan.write_value;

   // writes retire without a response slot
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign s1_advance = s1_valid_ff &&
                       (s1_req_ff.command == eau_pkg::CMD_WRITE || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_accept     = req_chan.valid && req_chan.ready;

   eau_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_accept),
      .rd_a_addr ({1'b1, req_chan.reg_req}),
      .rd_b_addr (req_chan.ext_word[eau_pkg::IDX_REG_LSB +: eau_pkg::REG_AW]),
      .wr        (rf_wr),
      .rd_a_data (an_val),
      .rd_b_data (idx_val)
   );

   eau_agen u_agen (
      .req       (s1_req_ff),
      .an_val    (an_val),
      .idx_val   (idx_val),
      .last_addr (mem_last_ff),
      .rsp       (agen_rsp),
      .wb        (agen_wb)
   );

   always_comb begin
      rf_wr    = agen_wb;
      rf_wr.en = agen_wb.en && s1_advance;
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s1_advance && s1_req_ff.command == eau_pkg::CMD_RESOLVE) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mem_last_ff  <= '1;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            mem_last_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_in;
      end
      if (s1_advance && s1_req_ff.command == eau_pkg::CMD_RESOLVE) begin
         rsp_data_ff <= agen_rsp;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.kind       = rsp_data_ff.kind;
   assign rsp_chan.reg_number = rsp_data_ff.reg_number;
   assign rsp_chan.address    = rsp_data_ff.address;
   assign rsp_chan.words_used = rsp_data_ff.words_used;
   assign rsp_chan.error_code = rsp_data_ff.error_code;

endmodule
